FILE: rtl/mlpe_pkg.sv
// Shared types, constants and helpers for the MLP inference block with ELU.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none
package mlpe_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int MAX_WIDTH    = 256;
  localparam int MAX_ACTIONS  = 64;
  localparam int WEIGHT_WORDS = 65536;
  localparam int BIAS_WORDS   = 1024;
  localparam int ELU_ENTRIES  = 256;
  localparam int ELU_TAB_BITS = $clog2(ELU_ENTRIES);
  localparam int WA_BITS      = $clog2(WEIGHT_WORDS);
  localparam int BA_BITS      = $clog2(BIAS_WORDS);
  localparam int AW           = $clog2(MAX_WIDTH);

  typedef logic signed [31:0] word_t;
  typedef word_t elu_tab_t [ELU_ENTRIES+1];

  typedef enum logic [2:0] {
    OP_WEIGHT  = 3'd0,
    OP_BIAS    = 3'd1,
    OP_MEAN    = 3'd2,
    OP_INV_DEV = 3'd3,
    OP_OBS     = 3'd4,
    OP_RUN     = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    REG_LAYERS = 3'd0,
    REG_INPUT  = 3'd1,
    REG_HID1   = 3'd2,
    REG_HID2   = 3'd3,
    REG_HID3   = 3'd4,
    REG_ACTION = 3'd5
  } reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_NDRAIN,
    ST_ROW,
    ST_RWAIT
  } state_t;

  typedef struct packed {
    logic       valid;
    logic       last;
    logic [5:0] idx;
    word_t      value;
  } act_ent_t;

  // Saturate a 49-bit signed value to 32 bits.
  function automatic word_t sat32(input logic signed [48:0] v);
    if (v[48:31] != {18{v[48]}}) begin
      return v[48] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return v[31:0];
  endfunction

  // Clamp a width register to 1..MAX_WIDTH.
  function automatic logic [8:0] clamp_w(input logic [8:0] w);
    if (w == 9'd0) begin
      return 9'd1;
    end
    if (w > 9'(MAX_WIDTH)) begin
      return 9'(MAX_WIDTH);
    end
    return w;
  endfunction

  // exp(x)-1 table on [-8, 0], Q(FRAC_BITS), evaluated at elaboration.
  function automatic elu_tab_t build_elu_tab();
    elu_tab_t     tab;
    logic [63:0]  t;
    logic [63:0]  s;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [63:0]  r;
    logic [127:0] wide;
    for (int k = 0; k <= ELU_ENTRIES; k++) begin
      t    = ((64'd8 * 64'(k)) << 32) / 64'(ELU_ENTRIES);
      s    = t >> 4;
      term = 64'd1 << 32;
      sum  = term;
      for (int n = 1; n <= 12; n++) begin
        wide = 128'(term) * 128'(s);
        term = 64'(wide >> 32) / 64'(n);
        if ((n % 2) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      for (int n = 0; n < 4; n++) begin
        if (sum < (64'd1 << 32)) begin
          wide = 128'(sum) * 128'(sum);
          sum  = 64'(wide >> 32);
        end
      end
      r      = (sum + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
      tab[k] = word_t'(r - (64'd1 << FRAC_BITS));
    end
    return tab;
  endfunction

  localparam elu_tab_t ELU_TAB = build_elu_tab();

endpackage
`default_nettype wire

FILE: rtl/mlpe_elu.sv
// Three-stage ELU unit: table lookup with linear interpolation.
// Depends on mlpe_pkg (ELU_TAB, sat32, FRAC_BITS).
`default_nettype none
module mlpe_elu (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_v,
  input  wire mlpe_pkg::word_t x,
  output logic               out_v,
  output mlpe_pkg::word_t    y
);
  import mlpe_pkg::*;

  localparam int ULIM = FRAC_BITS + 3;
  localparam int ILO  = ULIM - ELU_TAB_BITS;

  typedef enum logic [1:0] {EM_TAB, EM_PASS, EM_FLOOR, EM_END} elu_mode_t;

  logic signed [32:0]      u;
  logic [ELU_TAB_BITS-1:0] idx;
  elu_mode_t               mode;

  logic                    v1_r, v2_r, v3_r;
  elu_mode_t               mode1_r, mode2_r;
  word_t                   x1_r, x2_r, lo1_r, lo2_r, y_r;
  logic signed [32:0]      diff1_r;
  logic [ILO-1:0]          frac1_r;
  logic signed [33+ILO:0]  m2_r;

  always_comb begin
    u   = -{x[31], x};
    idx = u[ULIM-1:ILO];
    if (!x[31] && (x != 32'sd0)) begin
      mode = EM_PASS;
    end else if (u > 33'sd1 <<< ULIM) begin
      mode = EM_FLOOR;
    end else if (u == 33'sd1 <<< ULIM) begin
      mode = EM_END;
    end else begin
      mode = EM_TAB;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    mode1_r <= mode;
    x1_r    <= x;
    lo1_r   <= ELU_TAB[int'(idx)];
    diff1_r <= {ELU_TAB[int'(idx) + 1][31], ELU_TAB[int'(idx) + 1]}
             - {ELU_TAB[int'(idx)][31], ELU_TAB[int'(idx)]};
    frac1_r <= u[ILO-1:0];
    mode2_r <= mode1_r;
    x2_r    <= x1_r;
    lo2_r   <= lo1_r;
    m2_r    <= (34+ILO)'(diff1_r * $signed({1'b0, frac1_r}));
    case (mode2_r)
      EM_PASS:  y_r <= x2_r;
      EM_FLOOR: y_r <= -(32'sd1 <<< FRAC_BITS);
      EM_END:   y_r <= ELU_TAB[ELU_ENTRIES];
      default:  y_r <= sat32(49'(lo2_r) + 49'(m2_r >>> ILO));
    endcase
  end

  assign out_v = v3_r;
  assign y     = y_r;

endmodule
`default_nettype wire

FILE: rtl/mlpe_cell.sv
// One cell of the result chain: holds one action entry, takes its neighbor's.
// Depends on mlpe_pkg (act_ent_t).
`default_nettype none
module mlpe_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire mlpe_pkg::act_ent_t up,
  output mlpe_pkg::act_ent_t      ent
);
  import mlpe_pkg::*;

  act_ent_t ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else if (en) begin
      ent_r <= up;
    end
  end

  assign ent = ent_r;

endmodule
`default_nettype wire

FILE: rtl/mlp_inference_elu.sv
// MLP inference with ELU: parameter stores, normalizer, MAC datapath, result chain.
// Depends on mlpe_pkg, mlpe_elu, mlpe_cell.
// A write request is taken while idle, one per cycle back to back.
// A run request first normalizes the inputs, then works through each hidden neuron
// and each action neuron with one MAC per cycle, set by the single weight memory
// port. Results leave the cell chain one per cycle while the output is not stalled.
// Reset (rst_n low, synchronous) clears control, chain and config to defaults;
// the stores stay undefined until written.
`default_nettype none
module mlp_inference_elu (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // address[15:0], value[47:16]
  input  wire logic [2:0]  in_tuser,   // opcode[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // action_index[5:0], action_value[37:6], zero pad
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [8:0]  cfg_wdata
);
  import mlpe_pkg::*;

  // ---------------------------------------------------------------- stores
  word_t weight_mem [WEIGHT_WORDS];
  word_t bias_mem   [BIAS_WORDS];
  word_t mean_mem   [MAX_WIDTH];
  word_t inv_mem    [MAX_WIDTH];
  word_t obs_mem    [MAX_WIDTH];
  word_t ping_mem   [MAX_WIDTH];
  word_t pong_mem   [MAX_WIDTH];

  // ---------------------------------------------------------------- config
  logic [2:0] layer_count_r;
  logic [8:0] input_width_r, hid1_r, hid2_r, hid3_r;
  logic [6:0] action_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layer_count_r  <= 3'd4;
      input_width_r  <= 9'd64;
      hid1_r         <= 9'd256;
      hid2_r         <= 9'd256;
      hid3_r         <= 9'd128;
      action_width_r <= 7'd19;
    end else if (cfg_we) begin
      case (reg_t'(cfg_index))
        REG_LAYERS: layer_count_r  <= cfg_wdata[2:0];
        REG_INPUT:  input_width_r  <= cfg_wdata;
        REG_HID1:   hid1_r         <= cfg_wdata;
        REG_HID2:   hid2_r         <= cfg_wdata;
        REG_HID3:   hid3_r         <= cfg_wdata;
        REG_ACTION: action_width_r <= cfg_wdata[6:0];
        default:    ;
      endcase
    end
  end

  // Clamp the registers to their legal ranges.
  logic [2:0] layers_c;
  logic [8:0] act_c;
  always_comb begin
    if (layer_count_r == 3'd0) begin
      layers_c = 3'd1;
    end else if (layer_count_r > 3'd4) begin
      layers_c = 3'd4;
    end else begin
      layers_c = layer_count_r;
    end
    if (action_width_r == 7'd0) begin
      act_c = 9'd1;
    end else if (action_width_r > 7'(MAX_ACTIONS)) begin
      act_c = 9'(MAX_ACTIONS);
    end else begin
      act_c = {2'b00, action_width_r};
    end
  end

  // ---------------------------------------------------------------- input side
  logic        in_acc;
  op_t         op;
  logic [15:0] in_addr;
  word_t       in_val;

  assign in_acc  = in_tvalid && in_tready;
  assign op      = op_t'(in_tuser);
  assign in_addr = in_tdata[15:0];
  assign in_val  = in_tdata[47:16];

  // ---------------------------------------------------------------- control state
  state_t      state_r, state_nxt;
  logic [1:0]  layer_r, layer_nxt;
  logic [8:0]  row_r, row_nxt, col_r, col_nxt, n_in_r, n_in_nxt, n_out_r, n_out_nxt;
  logic [WA_BITS-1:0] wadr_r, wadr_nxt;
  logic [BA_BITS-1:0] badr_r, badr_nxt;
  logic        src_pong_r, src_pong_nxt;
  logic        done_r, done_nxt;

  logic        nv1_r, nv2_r, nv3_r;
  logic        v1_r, v2_r, first1_r, first2_r, last1_r, last2_r;
  logic        acc_done_r;
  word_t       acc_r;
  logic        elu_v;
  word_t       elu_y;

  logic        last_layer, col_end, row_end, row_adv, tail_full, load, run_go;
  logic [1:0]  wsel_idx;
  logic [8:0]  wsel;

  assign last_layer = ({1'b0, layer_r} + 3'd1) == layers_c;
  assign col_end    = col_r == (n_in_r - 9'd1);
  assign row_end    = row_r == (n_out_r - 9'd1);
  assign run_go     = in_acc && (op == OP_RUN);
  // Advance to the next neuron once its value is stored (hidden) or queued (action).
  assign row_adv    = (state_r == ST_RWAIT) && (last_layer ? (done_r && !tail_full) : elu_v);
  assign load       = (state_r == ST_RWAIT) && last_layer && done_r && !tail_full;

  // Output width of the layer about to start.
  always_comb begin
    wsel_idx = (state_r == ST_IDLE) ? 2'd0 : layer_r + 2'd1;
    case (wsel_idx)
      2'd0:    wsel = clamp_w(hid1_r);
      2'd1:    wsel = clamp_w(hid2_r);
      2'd2:    wsel = clamp_w(hid3_r);
      default: wsel = act_c;
    endcase
    if (({1'b0, wsel_idx} + 3'd1) == layers_c) begin
      wsel = act_c;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (run_go) state_nxt = ST_NORM;
      ST_NORM:   if (col_end) state_nxt = ST_NDRAIN;
      ST_NDRAIN: if (!(nv1_r || nv2_r || nv3_r)) state_nxt = ST_ROW;
      ST_ROW:    if (col_end) state_nxt = ST_RWAIT;
      ST_RWAIT: begin
        if (row_adv) begin
          state_nxt = (row_end && last_layer) ? ST_IDLE : ST_ROW;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Counters and layer bookkeeping.
  always_comb begin
    layer_nxt    = layer_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    n_in_nxt     = n_in_r;
    n_out_nxt    = n_out_r;
    wadr_nxt     = wadr_r;
    badr_nxt     = badr_r;
    src_pong_nxt = src_pong_r;
    done_nxt     = (done_r || acc_done_r) && !row_adv;
    case (state_r)
      ST_IDLE: begin
        col_nxt = 9'd0;
        if (run_go) begin
          layer_nxt    = 2'd0;
          row_nxt      = 9'd0;
          n_in_nxt     = clamp_w(input_width_r);
          n_out_nxt    = wsel;
          wadr_nxt     = '0;
          badr_nxt     = '0;
          src_pong_nxt = 1'b0;
          done_nxt     = 1'b0;
        end
      end
      ST_NORM: col_nxt = col_end ? 9'd0 : col_r + 9'd1;
      ST_ROW: begin
        col_nxt  = col_end ? 9'd0 : col_r + 9'd1;
        wadr_nxt = wadr_r + 1'b1;
      end
      ST_RWAIT: begin
        if (row_adv) begin
          badr_nxt = badr_r + 1'b1;
          if (row_end) begin
            // Layer done: swap buffers and move on.
            row_nxt      = 9'd0;
            layer_nxt    = layer_r + 2'd1;
            n_in_nxt     = n_out_r;
            n_out_nxt    = wsel;
            src_pong_nxt = !src_pong_r;
          end else begin
            row_nxt = row_r + 9'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      layer_r    <= 2'd0;
      row_r      <= 9'd0;
      col_r      <= 9'd0;
      n_in_r     <= 9'd1;
      n_out_r    <= 9'd1;
      wadr_r     <= '0;
      badr_r     <= '0;
      src_pong_r <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      layer_r    <= layer_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      n_in_r     <= n_in_nxt;
      n_out_r    <= n_out_nxt;
      wadr_r     <= wadr_nxt;
      badr_r     <= badr_nxt;
      src_pong_r <= src_pong_nxt;
      done_r     <= done_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  // ---------------------------------------------------------------- store ports
  word_t w_q, b_q, mean_q, inv_q, obs_q, ping_q, pong_q;
  logic  [AW-1:0] nidx1_r, nidx2_r, nidx3_r;
  word_t d2_r, inv2_r;
  logic signed [63:0] np3_r;
  word_t norm_val;
  logic  hid_wr, ping_we, pong_we;
  logic  [AW-1:0] ping_wa;
  word_t ping_wd;

  assign norm_val = sat32(49'(np3_r >>> FRAC_BITS));
  assign hid_wr   = (state_r == ST_RWAIT) && !last_layer && elu_v;
  assign ping_we  = nv3_r || (hid_wr && src_pong_r);
  assign pong_we  = hid_wr && !src_pong_r;
  assign ping_wa  = nv3_r ? nidx3_r : row_r[AW-1:0];
  assign ping_wd  = nv3_r ? norm_val : elu_y;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      case (op)
        OP_WEIGHT:  weight_mem[in_addr[WA_BITS-1:0]] <= in_val;
        OP_BIAS:    if (int'(in_addr) < BIAS_WORDS) bias_mem[in_addr[BA_BITS-1:0]] <= in_val;
        OP_MEAN:    if (int'(in_addr) < MAX_WIDTH) mean_mem[in_addr[AW-1:0]] <= in_val;
        OP_INV_DEV: if (int'(in_addr) < MAX_WIDTH) inv_mem[in_addr[AW-1:0]] <= in_val;
        OP_OBS:     if (int'(in_addr) < MAX_WIDTH) obs_mem[in_addr[AW-1:0]] <= in_val;
        default:    ;
      endcase
    end
    w_q    <= weight_mem[wadr_r];
    b_q    <= bias_mem[badr_r];
    mean_q <= mean_mem[col_r[AW-1:0]];
    inv_q  <= inv_mem[col_r[AW-1:0]];
    obs_q  <= obs_mem[col_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ping_we) begin
      ping_mem[ping_wa] <= ping_wd;
    end
    ping_q <= ping_mem[col_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (pong_we) begin
      pong_mem[row_r[AW-1:0]] <= elu_y;
    end
    pong_q <= pong_mem[col_r[AW-1:0]];
  end

  // ---------------------------------------------------------------- normalizer
  // Read, saturate the difference, multiply, then shift and saturate into ping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv1_r <= 1'b0;
      nv2_r <= 1'b0;
      nv3_r <= 1'b0;
    end else begin
      nv1_r <= (state_r == ST_NORM);
      nv2_r <= nv1_r;
      nv3_r <= nv2_r;
    end
    nidx1_r <= col_r[AW-1:0];
    nidx2_r <= nidx1_r;
    nidx3_r <= nidx2_r;
    d2_r    <= sat32(49'(obs_q) - 49'(mean_q));
    inv2_r  <= inv_q;
    np3_r   <= d2_r * inv2_r;
  end

  // ---------------------------------------------------------------- MAC datapath
  logic signed [63:0] prod2_r;
  word_t              b2_r, a_q;

  assign a_q = src_pong_r ? pong_q : ping_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      acc_done_r <= 1'b0;
    end else begin
      v1_r       <= (state_r == ST_ROW);
      v2_r       <= v1_r;
      acc_done_r <= v2_r && last2_r;
    end
    first1_r <= (col_r == 9'd0);
    last1_r  <= col_end;
    first2_r <= first1_r;
    last2_r  <= last1_r;
    prod2_r  <= w_q * a_q;
    b2_r     <= b_q;
    // Start each neuron from its bias; saturate after every add.
    if (v2_r) begin
      acc_r <= sat32((first2_r ? 49'(b2_r) : 49'(acc_r)) + 49'(prod2_r >>> FRAC_BITS));
    end
  end

  mlpe_elu u_elu (
    .clk   (clk),
    .rst_n (rst_n),
    .in_v  (acc_done_r && !last_layer),
    .x     (acc_r),
    .out_v (elu_v),
    .y     (elu_y)
  );

  // ---------------------------------------------------------------- result chain
  // Enter at the tail cell, drift toward the head, leave from the head.
  act_ent_t ent [MAX_ACTIONS];
  act_ent_t load_ent;
  logic     shift;

  assign shift          = !ent[0].valid || out_tready;
  assign tail_full      = ent[MAX_ACTIONS-1].valid;
  assign load_ent.valid = load;
  assign load_ent.last  = row_end;
  assign load_ent.idx   = row_r[5:0];
  assign load_ent.value = acc_r;

  for (genvar k = 0; k < MAX_ACTIONS; k++) begin : g_cell
    if (k == MAX_ACTIONS - 1) begin : g_tail
      mlpe_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (shift || load),
        .up    (load_ent),
        .ent   (ent[k])
      );
    end else begin : g_body
      mlpe_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (shift),
        .up    (ent[k+1]),
        .ent   (ent[k])
      );
    end
  end

  assign out_tvalid = ent[0].valid;
  assign out_tdata  = {2'b00, ent[0].value, ent[0].idx};
  assign out_tlast  = ent[0].last;

endmodule
`default_nettype wire

FILE: rtl/mlpe_chk.sv
// Port-level checker for mlp_inference_elu, bound to the top level.
// Depends on mlpe_pkg (op_t).
`default_nettype none
module mlpe_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [47:0] in_tdata,
  input wire logic [2:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic        cfg_we,
  input wire logic [2:0]  cfg_index,
  input wire logic [8:0]  cfg_wdata
);
  import mlpe_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // Reset empties the result chain.
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // Reset leaves the block ready for requests.
  a_rst_rdy: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("not ready after reset");

  // A run request makes the block busy.
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_RUN) |=> !in_tready)
    else $error("ready right after run request");

endmodule

bind mlp_inference_elu mlpe_chk u_mlpe_chk (.*);
`default_nettype wire
